// ===== rtl/hfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_pkg: shared types and constants of the harmonic field relaxation block
// Grid geometry, field widths, command codes, register indexes and the
// structs that travel between the top level and the relaxation core.
// ----------------------------------------------------------------------------
package hfr_pkg;

  // Grid geometry
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ADDR_W   = ROW_W + COL_W;
  localparam int unsigned CELLS    = MAX_ROWS * MAX_COLS;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);

  // Grid size registers and their clamp limits
  localparam int unsigned DIM_W = 7;
  localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);
  localparam logic [DIM_W-1:0] DIM_MAX_ROWS = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] DIM_MAX_COLS = DIM_W'(MAX_COLS);

  // Potential, unsigned Q0.16, all ones stands for 1.0
  localparam int unsigned POT_W = 16;
  localparam int unsigned SUM_W = POT_W + 2;
  localparam logic [POT_W-1:0] POT_FULL = {POT_W{1'b1}};

  // Other field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned OCC_W   = 16;
  localparam int unsigned SWEEP_W = 8;
  localparam int unsigned THR_W   = 16;

  // Stream and configuration port widths
  localparam int unsigned IN_W      = 32;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBST_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [OCC_W-1:0]  occupancy;
    logic              known;
  } cmd_t;

  typedef struct packed {
    logic [SWEEP_W-1:0] sweep_count;
    logic [THR_W-1:0]   obstacle_threshold;
    logic [DIM_W-1:0]   nr;   // clamped rows in use
    logic [DIM_W-1:0]   nc;   // clamped columns in use
  } cfg_t;

  typedef struct packed {
    logic [POT_W-1:0] potential;
    logic             is_obstacle;
    logic             is_known;
    logic             done_res;
  } res_t;

  typedef struct packed {
    logic known;
    logic obstacle;
  } flags_t;

  // Accumulator control: load restarts the sum, add accumulates
  typedef struct packed {
    logic load;
    logic add;
  } acc_ctl_t;

endpackage

// ===== rtl/hfr_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_accum: shared neighbor accumulator
// One adder sums the four neighbor potentials of a cell.
// ----------------------------------------------------------------------------
module hfr_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hfr_pkg::acc_ctl_t         ctl_i,
  input  logic [hfr_pkg::POT_W-1:0] operand_i,
  output logic [hfr_pkg::SUM_W-1:0] sum_o
);

  logic [hfr_pkg::SUM_W-1:0] acc_q, acc_d;
  logic [hfr_pkg::SUM_W-1:0] base;

  // Load drops the old sum so the same adder serves both operations
  assign base  = ctl_i.load ? '0 : acc_q;
  assign sum_o = base + {2'b00, operand_i};

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.load || ctl_i.add) begin
      acc_d = sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== rtl/hfr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_core: cell memories and relaxation sequencer
// Holds the flag memory and the double-buffered field memory, and walks the
// grid cell by cell for clearing, run setup and Jacobi sweeps.
// ----------------------------------------------------------------------------
module hfr_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  hfr_pkg::cmd_t cmd_i,
  input  hfr_pkg::cfg_t cfg_i,
  output logic          idle_o,
  output logic          res_valid_o,
  output hfr_pkg::res_t res_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_INIT  = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;

  // Sweep steps: the read issued in each step, data arrives one step later
  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_UP     = 3'd1;
  localparam logic [2:0] STEP_DOWN   = 3'd2;
  localparam logic [2:0] STEP_LEFT   = 3'd3;
  localparam logic [2:0] STEP_RIGHT  = 3'd4;
  localparam logic [2:0] STEP_WRITE  = 3'd5;

  localparam int unsigned FADDR_W = hfr_pkg::ADDR_W + 1;

  logic [2:0]                  st_q, st_d;
  logic [hfr_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [2:0]                  step_q, step_d;
  logic                        bank_q, bank_d;
  logic [hfr_pkg::SWEEP_W-1:0] sweeps_q, sweeps_d;
  logic                        rd_inside_q, rd_inside_d;
  logic [hfr_pkg::POT_W-1:0]   center_q, center_d;

  // Memories
  hfr_pkg::flags_t           flag_mem [hfr_pkg::CELLS];
  logic [hfr_pkg::POT_W-1:0] fld_mem  [2*hfr_pkg::CELLS];

  logic                       flag_we, flag_re;
  logic [hfr_pkg::ADDR_W-1:0] flag_waddr, flag_raddr;
  hfr_pkg::flags_t            flag_wdata, flag_rdata_q;

  logic                      fld_we, fld_re;
  logic [FADDR_W-1:0]        fld_waddr, fld_raddr;
  logic [hfr_pkg::POT_W-1:0] fld_wdata, fld_rdata_q;

  hfr_pkg::acc_ctl_t         acc_ctl;
  logic [hfr_pkg::SUM_W-1:0] acc_sum;

  logic [hfr_pkg::ROW_W-1:0]  row_cur;
  logic [hfr_pkg::COL_W-1:0]  col_cur;
  logic [hfr_pkg::ADDR_W-1:0] cmd_addr;
  logic                       cmd_inside;
  logic                       interior;
  logic                       upd;
  logic                       last_cell;

  assign row_cur   = addr_q[hfr_pkg::ADDR_W-1:hfr_pkg::COL_W];
  assign col_cur   = addr_q[hfr_pkg::COL_W-1:0];
  assign cmd_addr  = {cmd_i.row, cmd_i.col};
  assign last_cell = (addr_q == hfr_pkg::ADDR_LAST);

  assign cmd_inside = ({1'b0, cmd_i.row} < cfg_i.nr) && ({1'b0, cmd_i.col} < cfg_i.nc);

  assign interior = (row_cur != '0) && (col_cur != '0)
                 && (({1'b0, row_cur} + hfr_pkg::DIM_W'(1)) < cfg_i.nr)
                 && (({1'b0, col_cur} + hfr_pkg::DIM_W'(1)) < cfg_i.nc);

  assign upd = interior && flag_rdata_q.known && !flag_rdata_q.obstacle;

  assign idle_o = (st_q == ST_IDLE);

  hfr_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (acc_ctl),
    .operand_i (fld_rdata_q),
    .sum_o     (acc_sum)
  );

  always_comb begin
    st_d        = st_q;
    addr_d      = addr_q;
    step_d      = step_q;
    bank_d      = bank_q;
    sweeps_d    = sweeps_q;
    rd_inside_d = rd_inside_q;
    center_d    = center_q;

    flag_we    = 1'b0;
    flag_waddr = addr_q;
    flag_wdata = '0;
    flag_re    = 1'b0;
    flag_raddr = addr_q;
    fld_we     = 1'b0;
    fld_waddr  = {bank_q, addr_q};
    fld_wdata  = '0;
    fld_re     = 1'b0;
    fld_raddr  = {bank_q, addr_q};
    acc_ctl    = '0;

    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (st_q)
      ST_CLEAR: begin
        // Zero flags and the first field bank, one cell per cycle
        flag_we   = 1'b1;
        fld_we    = 1'b1;
        fld_waddr = {1'b0, addr_q};
        addr_d    = addr_q + hfr_pkg::ADDR_W'(1);
        if (last_cell) begin
          st_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_i.func)
            hfr_pkg::FUNC_LOAD: begin
              flag_we             = cmd_inside;
              flag_waddr          = cmd_addr;
              flag_wdata.known    = cmd_i.known;
              flag_wdata.obstacle = cmd_i.known
                                 && (cmd_i.occupancy > cfg_i.obstacle_threshold);
              res_valid_o         = 1'b1;
              res_o.done_res      = 1'b1;
            end
            hfr_pkg::FUNC_RUN: begin
              st_d   = ST_INIT;
              addr_d = '0;
              step_d = '0;
              bank_d = 1'b0;
            end
            hfr_pkg::FUNC_READ: begin
              flag_re     = 1'b1;
              flag_raddr  = cmd_addr;
              fld_re      = 1'b1;
              fld_raddr   = {bank_q, cmd_addr};
              rd_inside_d = cmd_inside;
              st_d        = ST_READ;
            end
            default: begin
              // Undefined command: empty result, no state change
              res_valid_o = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        res_valid_o       = 1'b1;
        res_o.potential   = rd_inside_q ? fld_rdata_q : '0;
        res_o.is_obstacle = rd_inside_q && flag_rdata_q.obstacle;
        res_o.is_known    = rd_inside_q && flag_rdata_q.known;
        res_o.done_res    = 1'b1;
        st_d              = ST_IDLE;
      end

      ST_INIT: begin
        // Two steps per cell: fetch flags, then seed bank zero
        if (step_q[0] == 1'b0) begin
          flag_re = 1'b1;
          step_d  = 3'd1;
        end else begin
          fld_we    = 1'b1;
          fld_waddr = {1'b0, addr_q};
          fld_wdata = flag_rdata_q.obstacle ? hfr_pkg::POT_FULL : '0;
          step_d    = '0;
          addr_d    = addr_q + hfr_pkg::ADDR_W'(1);
          if (last_cell) begin
            sweeps_d = '0;
            if (cfg_i.sweep_count == '0) begin
              st_d           = ST_IDLE;
              res_valid_o    = 1'b1;
              res_o.done_res = 1'b1;
            end else begin
              st_d = ST_SWEEP;
            end
          end
        end
      end

      ST_SWEEP: begin
        case (step_q)
          STEP_CENTER: begin
            flag_re = 1'b1;
            fld_re  = 1'b1;
            step_d  = STEP_UP;
          end
          STEP_UP: begin
            fld_re    = 1'b1;
            fld_raddr = {bank_q, row_cur - hfr_pkg::ROW_W'(1), col_cur};
            center_d  = fld_rdata_q;
            step_d    = STEP_DOWN;
          end
          STEP_DOWN: begin
            fld_re       = 1'b1;
            fld_raddr    = {bank_q, row_cur + hfr_pkg::ROW_W'(1), col_cur};
            acc_ctl.load = 1'b1;
            step_d       = STEP_LEFT;
          end
          STEP_LEFT: begin
            fld_re      = 1'b1;
            fld_raddr   = {bank_q, row_cur, col_cur - hfr_pkg::COL_W'(1)};
            acc_ctl.add = 1'b1;
            step_d      = STEP_RIGHT;
          end
          STEP_RIGHT: begin
            fld_re      = 1'b1;
            fld_raddr   = {bank_q, row_cur, col_cur + hfr_pkg::COL_W'(1)};
            acc_ctl.add = 1'b1;
            step_d      = STEP_WRITE;
          end
          STEP_WRITE: begin
            // Right neighbor arrives now; write the mean or copy the center
            acc_ctl.add = 1'b1;
            fld_we      = 1'b1;
            fld_waddr   = {~bank_q, addr_q};
            fld_wdata   = upd ? acc_sum[hfr_pkg::SUM_W-1:2] : center_q;
            step_d      = STEP_CENTER;
            addr_d      = addr_q + hfr_pkg::ADDR_W'(1);
            if (last_cell) begin
              bank_d   = ~bank_q;
              sweeps_d = sweeps_q + hfr_pkg::SWEEP_W'(1);
              if ((sweeps_q + hfr_pkg::SWEEP_W'(1)) == cfg_i.sweep_count) begin
                st_d           = ST_IDLE;
                res_valid_o    = 1'b1;
                res_o.done_res = 1'b1;
              end
            end
          end
          default: begin
            step_d = STEP_CENTER;
          end
        endcase
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      addr_q      <= '0;
      step_q      <= '0;
      bank_q      <= 1'b0;
      sweeps_q    <= '0;
      rd_inside_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      addr_q      <= addr_d;
      step_q      <= step_d;
      bank_q      <= bank_d;
      sweeps_q    <= sweeps_d;
      rd_inside_q <= rd_inside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    center_q <= center_d;
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (flag_re) begin
      flag_rdata_q <= flag_mem[flag_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fld_we) begin
      fld_mem[fld_waddr] <= fld_wdata;
    end
    if (fld_re) begin
      fld_rdata_q <= fld_mem[fld_raddr];
    end
  end

  // Assertions
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (st_q == ST_IDLE))
    else $error("command started while the core is busy");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLEAR) |-> !res_valid_o)
    else $error("result produced during the clearing pass");

  a_sweep_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SWEEP && fld_we) |-> (step_q == STEP_WRITE))
    else $error("field written outside the write step of a sweep");

  a_sweep_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SWEEP && fld_we) |-> (fld_waddr[FADDR_W-1] != bank_q))
    else $error("sweep wrote into the bank it reads");

  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SWEEP && step_q == STEP_WRITE && last_cell) |=> (bank_q != $past(bank_q)))
    else $error("bank did not swap at the end of a sweep");

endmodule

// ===== rtl/harmonic_field_relaxation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_field_relaxation: harmonic potential field on a 64 x 64 grid
// Loads occupancy cells, relaxes a potential field with Jacobi sweeps and
// reads back the potential of a cell.
// ----------------------------------------------------------------------------
// Every command beat returns exactly one result beat. A run seeds the field
// (flag fetch, then write of each cell) and then sweeps: every sweep walks
// all 4096 cells, and each cell costs five reads on the single read port of
// the field memory (center and four neighbors) plus the write, with one
// shared adder summing the neighbors. The field memory is double buffered:
// a sweep reads one bank and writes the other, and the banks swap at the end
// of each sweep. After reset the block runs a clearing pass over the flag
// memory and the first field bank and accepts no command until it ends;
// configuration writes are taken at all times but must only change while the
// block is idle. The grid size registers are clamped to 3..64 when used.
// ----------------------------------------------------------------------------
module harmonic_field_relaxation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command beats: func[1:0], row[7:2], col[13:8], occupancy[29:14],
  // known[30], zero[31]
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [hfr_pkg::IN_W-1:0]      s_axis_tdata_i,
  // Result beats: potential[15:0], is_obstacle[16], is_known[17],
  // done_res[18], zero[23:19]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [hfr_pkg::OUT_W-1:0]     m_axis_tdata_o,
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [hfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hfr_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [hfr_pkg::SWEEP_W-1:0] sweep_count_q, sweep_count_d;
  logic [hfr_pkg::THR_W-1:0]   obst_thr_q, obst_thr_d;
  logic [hfr_pkg::DIM_W-1:0]   rows_used_q, rows_used_d;
  logic [hfr_pkg::DIM_W-1:0]   cols_used_q, cols_used_d;

  // Output register
  logic                      m_valid_q, m_valid_d;
  logic [hfr_pkg::OUT_W-1:0] m_data_q, m_data_d;

  hfr_pkg::cmd_t cmd;
  hfr_pkg::cfg_t cfg;
  hfr_pkg::res_t res;
  logic          core_idle;
  logic          res_valid;
  logic          start;

  // Unpack the command beat
  assign cmd.func      = s_axis_tdata_i[1:0];
  assign cmd.row       = s_axis_tdata_i[7:2];
  assign cmd.col       = s_axis_tdata_i[13:8];
  assign cmd.occupancy = s_axis_tdata_i[29:14];
  assign cmd.known     = s_axis_tdata_i[30];

  // Clamp the grid size to the supported range
  always_comb begin
    cfg.sweep_count        = sweep_count_q;
    cfg.obstacle_threshold = obst_thr_q;
    if (rows_used_q < hfr_pkg::DIM_MIN) begin
      cfg.nr = hfr_pkg::DIM_MIN;
    end else if (rows_used_q > hfr_pkg::DIM_MAX_ROWS) begin
      cfg.nr = hfr_pkg::DIM_MAX_ROWS;
    end else begin
      cfg.nr = rows_used_q;
    end
    if (cols_used_q < hfr_pkg::DIM_MIN) begin
      cfg.nc = hfr_pkg::DIM_MIN;
    end else if (cols_used_q > hfr_pkg::DIM_MAX_COLS) begin
      cfg.nc = hfr_pkg::DIM_MAX_COLS;
    end else begin
      cfg.nc = cols_used_q;
    end
  end

  // Accept a command only when the core is free and the result slot will
  // be free by the time the core answers
  assign s_axis_tready_o = core_idle && (!m_valid_q || m_axis_tready_i);
  assign start           = s_axis_tvalid_i && s_axis_tready_o;

  hfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Register writes
  always_comb begin
    sweep_count_d = sweep_count_q;
    obst_thr_d    = obst_thr_q;
    rows_used_d   = rows_used_q;
    cols_used_d   = cols_used_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        hfr_pkg::CFG_SWEEP_COUNT: sweep_count_d = cfg_data_i[hfr_pkg::SWEEP_W-1:0];
        hfr_pkg::CFG_OBST_THR:    obst_thr_d    = cfg_data_i[hfr_pkg::THR_W-1:0];
        hfr_pkg::CFG_ROWS_USED:   rows_used_d   = cfg_data_i[hfr_pkg::DIM_W-1:0];
        hfr_pkg::CFG_COLS_USED:   cols_used_d   = cfg_data_i[hfr_pkg::DIM_W-1:0];
        default: begin
          sweep_count_d = sweep_count_q;
        end
      endcase
    end
  end

  // Result slot: drop the beat once taken, load a new one when the core
  // reports
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (res_valid) begin
      m_valid_d = 1'b1;
      m_data_d  = {5'b00000, res.done_res, res.is_known, res.is_obstacle, res.potential};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_count_q <= hfr_pkg::SWEEP_W'(80);
      obst_thr_q    <= hfr_pkg::THR_W'(10);
      rows_used_q   <= hfr_pkg::DIM_MAX_ROWS;
      cols_used_q   <= hfr_pkg::DIM_MAX_COLS;
      m_valid_q     <= 1'b0;
    end else begin
      sweep_count_q <= sweep_count_d;
      obst_thr_q    <= obst_thr_d;
      rows_used_q   <= rows_used_d;
      cols_used_q   <= cols_used_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== tb/hfr_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_reply_checker: scoreboard for the harmonic field relaxation block
// Watches the command, result and register write channels, keeps its own
// copy of the grid and the field, and checks every result beat against it.
// ----------------------------------------------------------------------------
module hfr_reply_checker
  import hfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  logic                 cmd_ready_i,
  input  logic [IN_W-1:0]      cmd_data_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [OUT_W-1:0]     res_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   runs_o
);

  logic [SWEEP_W-1:0] sweep_cfg;
  logic [THR_W-1:0]   thr_cfg;
  logic [DIM_W-1:0]   rows_cfg;
  logic [DIM_W-1:0]   cols_cfg;

  bit               known_cells [CELLS];
  bit               blocked_cells [CELLS];
  logic [POT_W-1:0] field_q [CELLS];
  logic [POT_W-1:0] field_n [CELLS];

  res_t expected_replies [$];

  int fails   = 0;
  int checked = 0;
  int runs    = 0;
  int pending = 0;

  assign fail_count_o = fails;
  assign checked_o    = checked;
  assign runs_o       = runs;
  assign pending_o    = pending;

  function automatic int unsigned dim_in_use(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < DIM_MIN) return 32'(DIM_MIN);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // Seed obstacles at full scale, then Jacobi sweeps over the interior
  function automatic void relax_field();
    int unsigned nr, nc, k, s, r, c;
    logic [SUM_W-1:0] sum;
    nr = dim_in_use(rows_cfg, MAX_ROWS);
    nc = dim_in_use(cols_cfg, MAX_COLS);
    foreach (field_q[i]) field_q[i] = blocked_cells[i] ? POT_FULL : '0;
    for (s = 0; s < 32'(sweep_cfg); s++) begin
      field_n = field_q;
      for (r = 1; r + 1 < nr; r++) begin
        for (c = 1; c + 1 < nc; c++) begin
          k = r * MAX_COLS + c;
          if (known_cells[k] && !blocked_cells[k]) begin
            sum = SUM_W'(field_q[k - MAX_COLS]) + SUM_W'(field_q[k + MAX_COLS])
                + SUM_W'(field_q[k - 1]) + SUM_W'(field_q[k + 1]);
            field_n[k] = sum[SUM_W-1:2];
          end
        end
      end
      field_q = field_n;
    end
  endfunction

  function automatic res_t predict_reply(cmd_t c);
    res_t rep;
    int unsigned k;
    bit in_grid;
    rep = '0;
    in_grid = (32'(c.row) < dim_in_use(rows_cfg, MAX_ROWS))
           && (32'(c.col) < dim_in_use(cols_cfg, MAX_COLS));
    k = 32'(c.row) * MAX_COLS + 32'(c.col);
    case (c.func)
      FUNC_LOAD: begin
        if (in_grid) begin
          known_cells[k]   = c.known;
          blocked_cells[k] = c.known && (c.occupancy > thr_cfg);
        end
        rep.done_res = 1'b1;
      end
      FUNC_RUN: begin
        relax_field();
        rep.done_res = 1'b1;
      end
      FUNC_READ: begin
        if (in_grid) begin
          rep.potential   = field_q[k];
          rep.is_obstacle = blocked_cells[k];
          rep.is_known    = known_cells[k];
        end
        rep.done_res = 1'b1;
      end
      default: ;  // unknown code: no change, all-zero result
    endcase
    return rep;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails++;
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $time, checked, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    cmd_t cmd;
    res_t got;
    res_t want;
    if (!rst_ni) begin
      sweep_cfg = SWEEP_W'(80);
      thr_cfg   = THR_W'(10);
      rows_cfg  = DIM_MAX_ROWS;
      cols_cfg  = DIM_MAX_COLS;
      foreach (field_q[i]) begin
        known_cells[i]   = 1'b0;
        blocked_cells[i] = 1'b0;
        field_q[i]       = '0;
      end
      expected_replies.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SWEEP_COUNT: sweep_cfg = cfg_data_i[SWEEP_W-1:0];
          CFG_OBST_THR:    thr_cfg   = cfg_data_i[THR_W-1:0];
          CFG_ROWS_USED:   rows_cfg  = cfg_data_i[DIM_W-1:0];
          CFG_COLS_USED:   cols_cfg  = cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (cmd_valid_i && cmd_ready_i) begin
        // func[1:0], row[7:2], col[13:8], occupancy[29:14], known[30]
        cmd.func      = cmd_data_i[1:0];
        cmd.row       = cmd_data_i[7:2];
        cmd.col       = cmd_data_i[13:8];
        cmd.occupancy = cmd_data_i[29:14];
        cmd.known     = cmd_data_i[30];
        if (cmd.func == FUNC_RUN) runs++;
        expected_replies.push_back(predict_reply(cmd));
      end
      if (res_valid_i && res_ready_i) begin
        got.potential   = res_data_i[POT_W-1:0];
        got.is_obstacle = res_data_i[POT_W];
        got.is_known    = res_data_i[POT_W+1];
        got.done_res    = res_data_i[POT_W+2];
        if (expected_replies.size() == 0) begin
          report_mismatch("result with no command waiting", 32'(res_data_i), '0);
        end else begin
          want = expected_replies.pop_front();
          if (got.potential !== want.potential)
            report_mismatch("potential", 32'(got.potential), 32'(want.potential));
          if (got.is_obstacle !== want.is_obstacle)
            report_mismatch("is_obstacle", 32'(got.is_obstacle), 32'(want.is_obstacle));
          if (got.is_known !== want.is_known)
            report_mismatch("is_known", 32'(got.is_known), 32'(want.is_known));
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
          if (res_data_i[OUT_W-1:POT_W+3] !== '0)
            report_mismatch("pad bits", 32'(res_data_i[OUT_W-1:POT_W+3]), '0);
          checked++;
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

// ===== tb/harmonic_field_relaxation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_field_relaxation_tb: stimulus and verdict for the relaxation block
// Drives load, run, read and unknown commands over a series of grid setups,
// with random gaps on both streams, and lets the checker predict and compare
// every result beat.
// ----------------------------------------------------------------------------
module harmonic_field_relaxation_tb;
  import hfr_pkg::*;

  // Code outside the command set; the block must answer with an empty beat
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  localparam int unsigned ROUNDS      = 10;   // random grid setups
  localparam int unsigned IDLE_PCT    = 22;   // gap chance per cycle, both sides
  localparam int unsigned HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int unsigned NOISE_PCT   = 8;    // stray commands among well-formed ones

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int runs;

  // Shared between the sender and the receiver process
  bit steady        = 1'b0;  // no gaps on either side
  bit stall_request = 1'b0;  // ask the receiver for a long hold-off

  int unsigned sent = 0;

  // Register values in force, used to aim loads and reads at the grid
  logic [DIM_W-1:0] rows_now = DIM_MAX_ROWS;
  logic [DIM_W-1:0] cols_now = DIM_MAX_COLS;
  logic [THR_W-1:0] thr_now  = THR_W'(10);

  initial begin
    forever #5 clk = ~clk;
  end

  harmonic_field_relaxation DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  hfr_reply_checker reply_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .runs_o       (runs)
  );

  // Slowest correct run: the clear, two directed runs and nine random runs
  // of at most five sweeps each, with all stalls. Allow several times that.
  initial begin
    #100_000_000;
    $display("timeout: results stopped coming, %0d still expected", pending);
    $display("status: fail");
    $finish;
  end

  // Result side: random back-pressure, or a long hold-off on request.
  // One assignment to tready per falling edge.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        hold_left     = HOLD_CYCLES;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic int unsigned span(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < DIM_MIN) return 32'(DIM_MIN);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // Mostly small grids so that a few sweeps reach across; some out of range
  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2);
      1:       return $urandom_range(10, 127);
      default: return $urandom_range(3, 9);
    endcase
  endfunction

  function automatic int unsigned pick_thr();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 65535);
      1:       return $urandom_range(0, 31);
      2:       return $urandom_range(65500, 65535);
      default: return $urandom_range(100, 5000);
    endcase
  endfunction

  // Aim at both sides of the threshold, and right on it
  function automatic int unsigned pick_occ();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1: return 32'(thr_now);
      2: return (thr_now == '1) ? 32'(thr_now) : $urandom_range(32'(thr_now) + 1, 65535);
      default: return $urandom_range(0, 32'(thr_now));
    endcase
  endfunction

  // Offer one command beat, with random gaps, and hold it until accepted
  task automatic send_cmd(input logic [FUNC_W-1:0] func, input int unsigned row,
                          input int unsigned col, input int unsigned occ,
                          input bit known);
    bit placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid = 1'b0;
      end else begin
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, known, occ[OCC_W-1:0], col[COL_W-1:0],
                         row[ROW_W-1:0], func};
        placed = 1'b1;
      end
    end
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Drop valid, then wait for every result to come back
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DAT_W'(value);
  endtask

  // Write all four registers; call only with the block idle
  task automatic set_grid(input int unsigned sweeps, input int unsigned thr,
                          input int unsigned rows, input int unsigned cols);
    write_reg(CFG_SWEEP_COUNT, sweeps);
    write_reg(CFG_OBST_THR, thr);
    write_reg(CFG_ROWS_USED, rows);
    write_reg(CFG_COLS_USED, cols);
    @(negedge clk);
    cfg_we   = 1'b0;
    rows_now = DIM_W'(rows);
    cols_now = DIM_W'(cols);
    thr_now  = THR_W'(thr);
  endtask

  // Stray beat: unknown code, or a load or read outside the used grid if it is smaller than 64 x 64
  task automatic noise_cmd();
    int unsigned row, col;
    row = $urandom_range(0, 63);
    col = $urandom_range(0, 63);
    if (span(rows_now, MAX_ROWS) < MAX_ROWS)
      row = $urandom_range(span(rows_now, MAX_ROWS), 63);
    else if (span(cols_now, MAX_COLS) < MAX_COLS)
      col = $urandom_range(span(cols_now, MAX_COLS), 63);
    case ($urandom_range(0, 2))
      0: send_cmd(FUNC_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      1: send_cmd(FUNC_LOAD, row, col, $urandom_range(0, 65535),
                  1'($urandom_range(0, 1)));
      default: send_cmd(FUNC_READ, row, col, $urandom_range(0, 65535),
                        1'($urandom_range(0, 1)));
    endcase
  endtask

  task automatic load_cell();
    if ($urandom_range(99) < NOISE_PCT)
      noise_cmd();
    else
      send_cmd(FUNC_LOAD, $urandom_range(0, span(rows_now, MAX_ROWS) - 1),
               $urandom_range(0, span(cols_now, MAX_COLS) - 1), pick_occ(),
               $urandom_range(99) < 85);
  endtask

  task automatic read_cell();
    if ($urandom_range(99) < NOISE_PCT)
      noise_cmd();
    else
      send_cmd(FUNC_READ, $urandom_range(0, span(rows_now, MAX_ROWS) - 1),
               $urandom_range(0, span(cols_now, MAX_COLS) - 1),
               $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int unsigned round, sweeps, thr, rows, cols;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: 64 x 64, threshold 10. The first beat waits out the
    // clearing pass. Check the cleared state, the threshold edge, the far
    // corner and an unknown cell that must never count as an obstacle.
    send_cmd(FUNC_READ, 0, 0, 0, 1'b0);
    send_cmd(FUNC_LOAD, 63, 63, 65535, 1'b1);
    send_cmd(FUNC_LOAD, 0, 0, 11, 1'b1);
    send_cmd(FUNC_LOAD, 0, 1, 10, 1'b1);
    send_cmd(FUNC_LOAD, 1, 0, 65535, 1'b0);
    send_cmd(FUNC_READ, 63, 63, 0, 1'b0);
    send_cmd(FUNC_READ, 0, 0, 0, 1'b0);
    send_cmd(FUNC_READ, 0, 1, 0, 1'b0);
    send_cmd(FUNC_READ, 1, 0, 0, 1'b0);
    send_cmd(FUNC_NONE, 63, 63, 65535, 1'b1);

    // Rows below range clamp to 3, columns above range to 64; zero sweeps
    // only seed the obstacles. Cells past row 2 are now outside the grid.
    drain();
    set_grid(0, 10, 0, 127);
    send_cmd(FUNC_LOAD, 1, 1, 0, 1'b1);
    send_cmd(FUNC_LOAD, 0, 1, 65535, 1'b1);
    send_cmd(FUNC_LOAD, 5, 5, 65535, 1'b1);
    send_cmd(FUNC_RUN, 0, 0, 0, 1'b0);
    send_cmd(FUNC_READ, 0, 1, 0, 1'b0);
    send_cmd(FUNC_READ, 1, 1, 0, 1'b0);
    send_cmd(FUNC_READ, 63, 63, 0, 1'b0);
    send_cmd(FUNC_READ, 5, 5, 0, 1'b0);

    // 3 x 3 grid, one sweep, threshold at the top: the single interior cell
    // takes a quarter of full scale; flags loaded earlier keep their value.
    drain();
    set_grid(1, 65535, 3, 3);
    send_cmd(FUNC_LOAD, 2, 2, 65535, 1'b1);
    send_cmd(FUNC_RUN, 0, 0, 0, 1'b0);
    send_cmd(FUNC_READ, 1, 1, 0, 1'b0);
    send_cmd(FUNC_READ, 2, 2, 0, 1'b0);
    send_cmd(FUNC_READ, 0, 0, 0, 1'b0);

    // Random setups: load a map, read some flags, relax, read the field.
    for (round = 0; round < ROUNDS; round++) begin
      drain();
      sweeps = $urandom_range(1, 5);
      thr    = pick_thr();
      rows   = pick_dim();
      cols   = pick_dim();
      case (round)
        1: begin
          rows = 127;
          cols = 2;
        end
        2: begin
          rows = 64;
          cols = 64;
        end
        3: thr = 0;
        4: thr = 65535;
        5: sweeps = 255;  // set only; a full run would take too long
        default: ;
      endcase
      steady = (round == 6);
      set_grid(sweeps, thr, rows, cols);

      // Hold off the result side while loads keep coming: the block
      // backs up and must stall the command side.
      if (round == 0) stall_request = 1'b1;

      repeat (55) load_cell();

      // Sender pauses until every result is back, then resumes
      if (round == 7) drain();

      repeat (10) read_cell();
      if (round != 5)
        send_cmd(FUNC_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      repeat (50) read_cell();
    end
    steady = 1'b0;

    // Let the tail of results arrive, then give the verdict
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("coverage: %0d command beats over %0d grid setups, %0d relaxation runs",
             sent, ROUNDS + 3, runs);
    $display("results compared: %0d, mismatches: %0d", checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
